### rtl/stl_pkg.sv
// Shared codes, command word and wait-state decode for the sorted timeout list.
`timescale 1ns / 1ps

package stl_pkg;

   localparam int TASK_ID_W    = 4;
   localparam int AMOUNT_W     = 31;
   localparam int WAIT_STATE_W = 3;
   localparam int SLOT_IDX_W   = 8;

   localparam logic [1:0] REQ_INSERT   = 2'd0;
   localparam logic [1:0] REQ_REMOVE   = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;
   localparam logic [1:0] REQ_SETSTATE = 2'd3;

   localparam logic [WAIT_STATE_W-1:0] WAIT_SLEEP      = 3'd0;
   localparam logic [WAIT_STATE_W-1:0] WAIT_PEND       = 3'd1;
   localparam logic [WAIT_STATE_W-1:0] WAIT_PEND_SUSP  = 3'd2;
   localparam logic [WAIT_STATE_W-1:0] WAIT_SLEEP_SUSP = 3'd3;

   typedef logic [1:0] cell_op_type;
   localparam cell_op_type CELL_HOLD     = 2'd0;
   localparam cell_op_type CELL_INSERT   = 2'd1;
   localparam cell_op_type CELL_DELETE   = 2'd2;
   localparam cell_op_type CELL_SETSTATE = 2'd3;

   typedef struct packed {
      cell_op_type             op;
      logic [SLOT_IDX_W-1:0]   pos;
      logic [SLOT_IDX_W-1:0]   slot;
      logic [WAIT_STATE_W-1:0] state;
   } cell_cmd_type;

   typedef struct packed {
      logic new_state;
      logic wake_reason;
      logic enqueue_ready;
      logic fatal;
   } wake_type;

   function automatic wake_type wake_decode(input logic [WAIT_STATE_W-1:0] st);
      wake_type w;
      w = '0;
      unique case (st)
         WAIT_SLEEP: begin
            w.enqueue_ready = 1'b1;
         end
         WAIT_PEND: begin
            w.wake_reason   = 1'b1;
            w.enqueue_ready = 1'b1;
         end
         WAIT_PEND_SUSP: begin
            w.new_state   = 1'b1;
            w.wake_reason = 1'b1;
         end
         WAIT_SLEEP_SUSP: begin
            w.new_state = 1'b1;
         end
         default: begin
            w.fatal = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/sorted_timeout_list.sv
// Sorted timer queue of waiting tasks: top level with control sequencer and cell chain.
`timescale 1ns / 1ps

// Usage: raise start with a request word while busy is low; the word is taken at that
// clock edge. The list lives in a row of TASK_SLOTS cells, head first, and every cell
// compares its own remaining time in parallel. Set-state and remove are carried out in
// the command state that follows acceptance. Insert passes through the command state
// and then the scan state, where one cell is probed per cycle from the head until the
// task lands; an insert with a zero delay or an out-of-range slot does nothing and
// returns to idle from the command state. Tick walks the list, and the sequencer visits
// one expired entry per cycle. Results come one per cycle on rsp_strobe, held back in a
// pending register and then registered, so the final one of a tick, flagged by rsp_last,
// shows in the first cycle with busy low; the receiver cannot stall them, so capture
// every strobed word. A tick with nothing expired gives no word at all.
module sorted_timeout_list #(
   parameter int TASK_SLOTS = 16,
   parameter int TICK_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [stl_pkg::TASK_ID_W-1:0]       req_task_id,
   input  logic [stl_pkg::AMOUNT_W-1:0]        req_amount,
   input  logic [stl_pkg::WAIT_STATE_W-1:0]    req_wait_state,
   output logic                                rsp_strobe,
   output logic [stl_pkg::TASK_ID_W-1:0]       rsp_expired_task,
   output logic                                rsp_new_state,
   output logic                                rsp_wake_reason,
   output logic                                rsp_enqueue_ready,
   output logic                                rsp_fatal,
   output logic                                rsp_last
);
   import stl_pkg::*;

   localparam int IdxW = $clog2(TASK_SLOTS);
   localparam int PosW = IdxW + 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [TICK_BITS-1:0]    now_ff, now_in;
   logic [PosW-1:0]         pos_ff, pos_in;

   // latched request word
   logic [1:0]              type_ff, type_in;
   logic [IdxW-1:0]         slot_ff, slot_in;
   logic                    in_range_ff, in_range_in;
   logic [TICK_BITS-1:0]    delay_ff, delay_in;
   logic [WAIT_STATE_W-1:0] ws_ff, ws_in;

   // result held in a pending register so that the last flag is known when it leaves
   logic                    pend_valid_ff, pend_valid_in;
   logic [IdxW-1:0]         pend_slot_ff, pend_slot_in;
   logic [WAIT_STATE_W-1:0] pend_state_ff, pend_state_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [TASK_ID_W-1:0]    rsp_task_ff;
   wake_type                rsp_wake_ff;

   // cell chain
   cell_cmd_type            cmd;
   logic [TICK_BITS-1:0]    ins_match;
   logic [TASK_SLOTS-1:0]   cell_valid;
   logic [IdxW-1:0]         cell_slot  [TASK_SLOTS];
   logic [WAIT_STATE_W-1:0] cell_state [TASK_SLOTS];
   logic [TICK_BITS-1:0]    cell_match [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]   cell_gt;
   logic [TASK_SLOTS-1:0]   cell_expired;
   logic [TASK_SLOTS-1:0]   cell_hit;

   logic [IdxW-1:0]         sel_idx;
   logic                    at_end;
   logic                    cur_expired;
   logic                    any_hit;
   logic [IdxW-1:0]         hit_pos;
   logic                    accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign sel_idx   = pos_ff[IdxW-1:0];
   assign at_end    = pos_ff == PosW'(TASK_SLOTS);
   assign ins_match = now_ff + delay_ff;
   assign any_hit   = |cell_hit;

   // slots are listed at most once, so the hit vector is one-hot or empty
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (cell_hit[i]) begin
            hit_pos = hit_pos | IdxW'(i);
         end
      end
   end

   // entry at the walk position; the entry stays only when its wait state is invalid
   assign cur_expired = !at_end && cell_valid[sel_idx] && cell_expired[sel_idx];

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      pos_in        = pos_ff;
      type_in       = type_ff;
      slot_in       = slot_ff;
      in_range_in   = in_range_ff;
      delay_in      = delay_ff;
      ws_in         = ws_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_state_in = pend_state_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      cmd           = '0;
      cmd.op        = CELL_HOLD;
      cmd.slot      = SLOT_IDX_W'(slot_ff);
      cmd.state     = ws_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               type_in     = req_type;
               slot_in     = IdxW'(req_task_id);
               in_range_in = int'(req_task_id) < TASK_SLOTS;
               delay_in    = TICK_BITS'(req_amount);
               ws_in       = req_wait_state;
               pos_in      = '0;
               if (req_type == REQ_TICK) begin
                  // advance the counter now; the walk sees the new time
                  now_in   = now_ff + TICK_BITS'(req_amount);
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            pos_in   = '0;
            unique case (type_ff)
               REQ_SETSTATE: begin
                  if (in_range_ff) begin
                     cmd.op = CELL_SETSTATE;
                  end
               end
               REQ_REMOVE: begin
                  if (in_range_ff && any_hit) begin
                     cmd.op  = CELL_DELETE;
                     cmd.pos = SLOT_IDX_W'(hit_pos);
                  end
               end
               REQ_INSERT: begin
                  // drop an old listing first, then search for the landing place
                  if (in_range_ff && (delay_ff != '0)) begin
                     state_in = ST_SCAN;
                     if (any_hit) begin
                        cmd.op  = CELL_DELETE;
                        cmd.pos = SLOT_IDX_W'(hit_pos);
                     end
                  end
               end
               REQ_TICK: begin
               end
            endcase
         end

         ST_SCAN: begin
            // land before the first entry with more time left, or at the tail
            if (cell_gt[sel_idx]) begin
               cmd.op   = CELL_INSERT;
               cmd.pos  = SLOT_IDX_W'(sel_idx);
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         ST_WALK: begin
            if (cur_expired) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = cell_slot[sel_idx];
               pend_state_in = cell_state[sel_idx];
               if (cell_state[sel_idx] <= WAIT_SLEEP_SUSP) begin
                  cmd.op  = CELL_DELETE;
                  cmd.pos = SLOT_IDX_W'(sel_idx);
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end else begin
               // walk is done: flush the held result as the last one
               rsp_strobe_in = pend_valid_ff;
               rsp_last_in   = pend_valid_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         pos_ff        <= pos_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      slot_ff       <= slot_in;
      in_range_ff   <= in_range_in;
      delay_ff      <= delay_in;
      ws_ff         <= ws_in;
      pend_slot_ff  <= pend_slot_in;
      pend_state_ff <= pend_state_in;
      rsp_last_ff   <= rsp_last_in;
      if (rsp_strobe_in) begin
         rsp_task_ff <= TASK_ID_W'(pend_slot_ff);
         rsp_wake_ff <= wake_decode(pend_state_ff);
      end
   end

   // cell chain, head at index zero
   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      logic                    pv, nv;
      logic [IdxW-1:0]         ps, ns;
      logic [WAIT_STATE_W-1:0] pst, nst;
      logic [TICK_BITS-1:0]    pm, nm;

      if (i == 0) begin : g_head
         assign pv  = 1'b0;
         assign ps  = '0;
         assign pst = '0;
         assign pm  = '0;
      end else begin : g_mid
         assign pv  = cell_valid[i-1];
         assign ps  = cell_slot[i-1];
         assign pst = cell_state[i-1];
         assign pm  = cell_match[i-1];
      end

      if (i == TASK_SLOTS - 1) begin : g_tail
         assign nv  = 1'b0;
         assign ns  = '0;
         assign nst = '0;
         assign nm  = '0;
      end else begin : g_body
         assign nv  = cell_valid[i+1];
         assign ns  = cell_slot[i+1];
         assign nst = cell_state[i+1];
         assign nm  = cell_match[i+1];
      end

      stl_cell #(
         .TASK_SLOTS (TASK_SLOTS),
         .TICK_BITS  (TICK_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IdxW'(i)),
         .cmd        (cmd),
         .now_ticks  (now_ff),
         .ins_delay  (delay_ff),
         .ins_match  (ins_match),
         .prev_valid (pv),
         .prev_slot  (ps),
         .prev_state (pst),
         .prev_match (pm),
         .next_valid (nv),
         .next_slot  (ns),
         .next_state (nst),
         .next_match (nm),
         .valid      (cell_valid[i]),
         .slot       (cell_slot[i]),
         .state      (cell_state[i]),
         .match      (cell_match[i]),
         .gt         (cell_gt[i]),
         .expired    (cell_expired[i]),
         .hit        (cell_hit[i])
      );
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_expired_task  = rsp_task_ff;
   assign rsp_new_state     = rsp_wake_ff.new_state;
   assign rsp_wake_reason   = rsp_wake_ff.wake_reason;
   assign rsp_enqueue_ready = rsp_wake_ff.enqueue_ready;
   assign rsp_fatal         = rsp_wake_ff.fatal;

   // results only come out of a walk
   a_strobe_from_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == ST_WALK)
      else $error("result word outside a tick walk");

   // no held result survives the end of a walk
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held result left behind after walk");

   // listed entries stay packed at the head of the chain
   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("gap in cell chain");

   // a slot is listed at most once
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> $onehot0(cell_hit))
      else $error("slot listed more than once");

   // the last flag marks a strobed word only
   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_strobe_ff)
      else $error("last flag without result word");

endmodule

### rtl/stl_cell.sv
// One list position: holds an entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps

module stl_cell #(
   parameter int TASK_SLOTS = 16,
   parameter int TICK_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(TASK_SLOTS)-1:0]       cell_index,
   input  stl_pkg::cell_cmd_type               cmd,
   input  logic [TICK_BITS-1:0]                now_ticks,
   input  logic [TICK_BITS-1:0]                ins_delay,
   input  logic [TICK_BITS-1:0]                ins_match,
   input  logic                                prev_valid,
   input  logic [$clog2(TASK_SLOTS)-1:0]       prev_slot,
   input  logic [stl_pkg::WAIT_STATE_W-1:0]    prev_state,
   input  logic [TICK_BITS-1:0]                prev_match,
   input  logic                                next_valid,
   input  logic [$clog2(TASK_SLOTS)-1:0]       next_slot,
   input  logic [stl_pkg::WAIT_STATE_W-1:0]    next_state,
   input  logic [TICK_BITS-1:0]                next_match,
   output logic                                valid,
   output logic [$clog2(TASK_SLOTS)-1:0]       slot,
   output logic [stl_pkg::WAIT_STATE_W-1:0]    state,
   output logic [TICK_BITS-1:0]                match,
   output logic                                gt,
   output logic                                expired,
   output logic                                hit
);
   import stl_pkg::*;

   localparam int IdxW = $clog2(TASK_SLOTS);

   logic                    valid_ff, valid_in;
   logic [IdxW-1:0]         slot_ff, slot_in;
   logic [WAIT_STATE_W-1:0] state_ff, state_in;
   logic [TICK_BITS-1:0]    match_ff, match_in;
   logic [TICK_BITS-1:0]    left;
   logic [IdxW-1:0]         pos;
   logic                    at_pos;
   logic                    past_pos;

   assign left     = match_ff - now_ticks;
   assign pos      = cmd.pos[IdxW-1:0];
   assign at_pos   = cell_index == pos;
   assign past_pos = cell_index > pos;

   assign gt      = !valid_ff || (left > ins_delay);
   assign expired = (left == '0) || left[TICK_BITS-1];
   assign hit     = valid_ff && (slot_ff == cmd.slot[IdxW-1:0]);

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      state_in = state_ff;
      match_in = match_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_SETSTATE: begin
            if (hit) begin
               state_in = cmd.state;
            end
         end
         CELL_DELETE: begin
            if (at_pos || past_pos) begin
               valid_in = next_valid;
               slot_in  = next_slot;
               state_in = next_state;
               match_in = next_match;
            end
         end
         CELL_INSERT: begin
            if (at_pos) begin
               valid_in = 1'b1;
               slot_in  = cmd.slot[IdxW-1:0];
               state_in = cmd.state;
               match_in = ins_match;
            end else if (past_pos) begin
               valid_in = prev_valid;
               slot_in  = prev_slot;
               state_in = prev_state;
               match_in = prev_match;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      state_ff <= state_in;
      match_ff <= match_in;
   end

   assign valid = valid_ff;
   assign slot  = slot_ff;
   assign state = state_ff;
   assign match = match_ff;

endmodule
